// ----- hdl/scd_pkg.sv -----
// Package for the soft/hard clip distortion block.
// Holds register formats, register indexes, the CORDIC angle table and the pipeline depth.
// No dependencies.
package scd_pkg;

   localparam int CORDIC_STEPS    = 30;
   localparam int ANGLE_FRAC      = 30;
   localparam int ANGLE_WIDTH     = 33;
   localparam int GAIN_FRAC       = 8;
   localparam int MIX_FRAC        = 16;
   localparam int DRIVE_WIDTH     = 17;
   localparam int MIX_WIDTH       = 17;
   localparam int VOL_WIDTH       = 18;
   localparam int CSR_DATA_WIDTH  = 18;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef logic [DRIVE_WIDTH-1:0]     drive_type;
   typedef logic [MIX_WIDTH-1:0]       mix_type;
   typedef logic [VOL_WIDTH-1:0]       vol_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type REG_DRIVE_GAIN  = 2'd0;
   localparam csr_index_type REG_HARD_MIX    = 2'd1;
   localparam csr_index_type REG_WET_MIX     = 2'd2;
   localparam csr_index_type REG_OUTPUT_GAIN = 2'd3;

   localparam drive_type DRIVE_GAIN_RESET  = 17'd256;
   localparam mix_type   HARD_MIX_RESET    = 17'd0;
   localparam mix_type   WET_MIX_RESET     = 17'd32768;
   localparam vol_type   OUTPUT_GAIN_RESET = 18'd65536;
   localparam mix_type   MIX_UNITY         = 17'd65536;

   // atan(2^-i) in units of pi/2 with 30 fraction bits.
   localparam logic [ANGLE_FRAC-1:0] CORDIC_ANGLE [CORDIC_STEPS] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
      30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
      30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
      30'd20,        30'd10,        30'd5,         30'd3,        30'd1
   };

   // Front end (2) + CORDIC (one per step) + angle rounding (1) + mixer (6).
   localparam int LATENCY = CORDIC_STEPS + 9;

endpackage

// ----- hdl/soft_hard_clip_distortion_top.sv -----
// Throughput: one sample per cycle; busy is high during reset and the cycle after it.
// The CORDIC takes one register stage per step, 30 of the 39 stages.
// Reset clears every stage's valid bit and loads the register defaults.
// The result strobe rsp_valid lasts one cycle; the receiver cannot stall.
module soft_hard_clip_distortion_top #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_in_sample,
   output logic                            rsp_valid,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_out_sample,
   output logic                            rsp_saturated,
   input  logic                            csr_write,
   input  scd_pkg::csr_index_type          csr_index,
   input  scd_pkg::csr_data_type           csr_wdata
);
   import scd_pkg::*;

   localparam int SW = SAMPLE_WIDTH;
   localparam logic signed [SW-1:0] OUT_HI = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] OUT_LO = {1'b1, {(SW-1){1'b0}}};

   drive_type drive_gain_ff;
   mix_type   hard_mix_ff;
   mix_type   wet_mix_ff;
   vol_type   output_gain_ff;
   logic      busy_ff;
   logic      accept;

   logic                  f_valid;
   logic signed [SW-1:0]  f_x;
   logic signed [SW+18:0] f_cx, f_cy;
   logic                  f_neg;
   logic signed [SW:0]    f_hard;
   logic                  c_valid;
   logic signed [SW-1:0]  c_x;
   logic signed [SW:0]    c_soft, c_hard;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b1;
         drive_gain_ff  <= DRIVE_GAIN_RESET;
         hard_mix_ff    <= HARD_MIX_RESET;
         wet_mix_ff     <= WET_MIX_RESET;
         output_gain_ff <= OUTPUT_GAIN_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               REG_DRIVE_GAIN:  drive_gain_ff  <= csr_wdata[DRIVE_WIDTH-1:0];
               REG_HARD_MIX:    hard_mix_ff    <= csr_wdata[MIX_WIDTH-1:0];
               REG_WET_MIX:     wet_mix_ff     <= csr_wdata[MIX_WIDTH-1:0];
               REG_OUTPUT_GAIN: output_gain_ff <= csr_wdata[VOL_WIDTH-1:0];
               default: ;
            endcase
         end
      end
   end

   // A transaction presented in a reset cycle would be flushed, so it is refused.
   assign busy   = busy_ff | reset;
   assign accept = start & ~busy;

   scd_front #(
      .SW (SW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_sample  (req_in_sample),
      .drive_gain (drive_gain_ff),
      .out_valid  (f_valid),
      .out_x      (f_x),
      .out_cx     (f_cx),
      .out_cy     (f_cy),
      .out_neg    (f_neg),
      .out_hard   (f_hard)
   );

   scd_cordic #(
      .SW (SW)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_cx     (f_cx),
      .in_cy     (f_cy),
      .in_x      (f_x),
      .in_neg    (f_neg),
      .in_hard   (f_hard),
      .out_valid (c_valid),
      .out_x     (c_x),
      .out_soft  (c_soft),
      .out_hard  (c_hard)
   );

   scd_mix #(
      .SW (SW)
   ) u_mix (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (c_valid),
      .in_x          (c_x),
      .in_soft       (c_soft),
      .in_hard       (c_hard),
      .hard_mix      (hard_mix_ff),
      .wet_mix       (wet_mix_ff),
      .output_gain   (output_gain_ff),
      .out_valid     (rsp_valid),
      .out_sample    (rsp_out_sample),
      .out_saturated (rsp_saturated)
   );

   // Every result corresponds to a transaction accepted earlier.
   a_result_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe without a matching accepted transaction");

   a_sat_only_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_saturated |-> rsp_valid)
      else $error("saturation flag outside a result cycle");

   a_sat_at_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_out_sample == OUT_HI || rsp_out_sample == OUT_LO))
      else $error("saturated result is not at a range limit");

endmodule

// ----- hdl/scd_front.sv -----
// Front end of the distortion pipeline: drive gain multiply, hard clamp and CORDIC seed.
// Two register stages. Depends on scd_pkg.
module scd_front #(
   parameter int SW = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic signed [SW-1:0]   in_sample,
   input  scd_pkg::drive_type     drive_gain,
   output logic                   out_valid,
   output logic signed [SW-1:0]   out_x,
   output logic signed [SW+18:0]  out_cx,
   output logic signed [SW+18:0]  out_cy,
   output logic                   out_neg,
   output logic signed [SW:0]     out_hard
);
   import scd_pkg::*;

   localparam int FB  = SW - 1;
   localparam int DFB = FB + GAIN_FRAC;
   localparam int DW  = SW + DRIVE_WIDTH;
   localparam int CW  = SW + 19;
   localparam int HW  = SW + 1;
   localparam logic signed [DW-1:0] D_ONE = DW'(1) << DFB;
   localparam logic signed [DW-1:0] D_NEG = -D_ONE;

   logic signed [DW:0]   prod;
   logic                 a_valid_ff;
   logic signed [SW-1:0] a_x_ff;
   logic signed [DW-1:0] a_d_ff;
   logic signed [DW-1:0] a_d_in;
   logic signed [CW-1:0] d_ext;
   logic signed [CW-1:0] cx_in, cy_in;
   logic signed [HW-1:0] hard_in;
   logic                 b_valid_ff;
   logic signed [SW-1:0] b_x_ff;
   logic signed [CW-1:0] b_cx_ff, b_cy_ff;
   logic                 b_neg_ff;
   logic signed [HW-1:0] b_hard_ff;

   assign prod   = in_sample * $signed({1'b0, drive_gain});
   assign a_d_in = prod[DW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_x_ff <= in_sample;
      a_d_ff <= a_d_in;
   end

   always_comb begin
      d_ext = {{(CW-DW){a_d_ff[DW-1]}}, a_d_ff};
      cy_in = a_d_ff[DW-1] ? -d_ext : d_ext;
      cx_in = '0;
      cx_in[DFB] = 1'b1;
      if (a_d_ff >= D_ONE) begin
         hard_in = '0;
         hard_in[FB] = 1'b1;
      end else if (a_d_ff <= D_NEG) begin
         hard_in = '0;
         hard_in[HW-1] = 1'b1;
         hard_in[FB] = 1'b1;
      end else begin
         // Inside the unit range the product drops its gain fraction bits.
         hard_in = a_d_ff[GAIN_FRAC +: HW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_x_ff    <= a_x_ff;
      b_cx_ff   <= cx_in;
      b_cy_ff   <= cy_in;
      b_neg_ff  <= a_d_ff[DW-1];
      b_hard_ff <= hard_in;
   end

   assign out_valid = b_valid_ff;
   assign out_x     = b_x_ff;
   assign out_cx    = b_cx_ff;
   assign out_cy    = b_cy_ff;
   assign out_neg   = b_neg_ff;
   assign out_hard  = b_hard_ff;

endmodule

// ----- hdl/scd_cordic_stage.sv -----
// One vectoring step of the arctangent CORDIC, registered.
// Shift amount and angle follow from the step index. Depends on scd_pkg.
module scd_cordic_stage #(
   parameter int SW  = 24,
   parameter int IDX = 0
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic signed [SW+18:0]                   in_cx,
   input  logic signed [SW+18:0]                   in_cy,
   input  logic signed [scd_pkg::ANGLE_WIDTH-1:0]  in_z,
   input  logic signed [SW-1:0]                    in_x,
   input  logic                                    in_neg,
   input  logic signed [SW:0]                      in_hard,
   output logic                                    out_valid,
   output logic signed [SW+18:0]                   out_cx,
   output logic signed [SW+18:0]                   out_cy,
   output logic signed [scd_pkg::ANGLE_WIDTH-1:0]  out_z,
   output logic signed [SW-1:0]                    out_x,
   output logic                                    out_neg,
   output logic signed [SW:0]                      out_hard
);
   import scd_pkg::*;

   localparam int CW = SW + 19;
   localparam logic signed [ANGLE_WIDTH-1:0] STEP_ANGLE =
      $signed({{(ANGLE_WIDTH-ANGLE_FRAC){1'b0}}, CORDIC_ANGLE[IDX]});

   logic signed [CW-1:0]          sx, sy;
   logic signed [CW-1:0]          cx_in, cy_in;
   logic signed [ANGLE_WIDTH-1:0] z_in;
   logic                          valid_ff;
   logic signed [CW-1:0]          cx_ff, cy_ff;
   logic signed [ANGLE_WIDTH-1:0] z_ff;
   logic signed [SW-1:0]          x_ff;
   logic                          neg_ff;
   logic signed [SW:0]            hard_ff;

   always_comb begin
      sx = in_cy >>> IDX;
      sy = in_cx >>> IDX;
      if (!in_cy[CW-1]) begin
         cx_in = in_cx + sx;
         cy_in = in_cy - sy;
         z_in  = in_z + STEP_ANGLE;
      end else begin
         cx_in = in_cx - sx;
         cy_in = in_cy + sy;
         z_in  = in_z - STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      z_ff    <= z_in;
      x_ff    <= in_x;
      neg_ff  <= in_neg;
      hard_ff <= in_hard;
   end

   assign out_valid = valid_ff;
   assign out_cx    = cx_ff;
   assign out_cy    = cy_ff;
   assign out_z     = z_ff;
   assign out_x     = x_ff;
   assign out_neg   = neg_ff;
   assign out_hard  = hard_ff;

endmodule

// ----- hdl/scd_cordic.sv -----
// Soft clip path: CORDIC step chain, then angle clamp, rounding and sign.
// Instantiates scd_cordic_stage. Depends on scd_pkg.
module scd_cordic #(
   parameter int SW = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [SW+18:0] in_cx,
   input  logic signed [SW+18:0] in_cy,
   input  logic signed [SW-1:0]  in_x,
   input  logic                  in_neg,
   input  logic signed [SW:0]    in_hard,
   output logic                  out_valid,
   output logic signed [SW-1:0]  out_x,
   output logic signed [SW:0]    out_soft,
   output logic signed [SW:0]    out_hard
);
   import scd_pkg::*;

   localparam int FB = SW - 1;
   localparam int CW = SW + 19;
   localparam logic signed [ANGLE_WIDTH-1:0] Z_MAX = ANGLE_WIDTH'(1) << ANGLE_FRAC;

   logic                          v_chain    [CORDIC_STEPS+1];
   logic signed [CW-1:0]          cx_chain   [CORDIC_STEPS+1];
   logic signed [CW-1:0]          cy_chain   [CORDIC_STEPS+1];
   logic signed [ANGLE_WIDTH-1:0] z_chain    [CORDIC_STEPS+1];
   logic signed [SW-1:0]          x_chain    [CORDIC_STEPS+1];
   logic                          neg_chain  [CORDIC_STEPS+1];
   logic signed [SW:0]            hard_chain [CORDIC_STEPS+1];

   logic signed [ANGLE_WIDTH-1:0] z_end;
   logic [ANGLE_FRAC:0]           z_clamp;
   logic [FB:0]                   mag;
   logic signed [SW:0]            soft_in;
   logic                          valid_ff;
   logic signed [SW-1:0]          x_ff;
   logic signed [SW:0]            soft_ff;
   logic signed [SW:0]            hard_ff;

   assign v_chain[0]    = in_valid;
   assign cx_chain[0]   = in_cx;
   assign cy_chain[0]   = in_cy;
   assign z_chain[0]    = '0;
   assign x_chain[0]    = in_x;
   assign neg_chain[0]  = in_neg;
   assign hard_chain[0] = in_hard;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      scd_cordic_stage #(
         .SW  (SW),
         .IDX (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v_chain[i]),
         .in_cx     (cx_chain[i]),
         .in_cy     (cy_chain[i]),
         .in_z      (z_chain[i]),
         .in_x      (x_chain[i]),
         .in_neg    (neg_chain[i]),
         .in_hard   (hard_chain[i]),
         .out_valid (v_chain[i+1]),
         .out_cx    (cx_chain[i+1]),
         .out_cy    (cy_chain[i+1]),
         .out_z     (z_chain[i+1]),
         .out_x     (x_chain[i+1]),
         .out_neg   (neg_chain[i+1]),
         .out_hard  (hard_chain[i+1])
      );
   end

   assign z_end = z_chain[CORDIC_STEPS];

   always_comb begin
      if (z_end[ANGLE_WIDTH-1]) begin
         z_clamp = '0;
      end else if (z_end > Z_MAX) begin
         z_clamp = Z_MAX[ANGLE_FRAC:0];
      end else begin
         z_clamp = z_end[ANGLE_FRAC:0];
      end
   end

   // Bring the angle from 30 fraction bits to the sample's fraction bits.
   if (FB < ANGLE_FRAC) begin : g_round
      localparam int RS = ANGLE_FRAC - FB;
      logic [ANGLE_FRAC+1:0] z_sum;
      assign z_sum = {1'b0, z_clamp} + ((ANGLE_FRAC+2)'(1) << (RS - 1));
      assign mag   = z_sum[RS +: FB+1];
   end else if (FB == ANGLE_FRAC) begin : g_exact
      assign mag = z_clamp;
   end else begin : g_widen
      assign mag = {z_clamp, {(FB-ANGLE_FRAC){1'b0}}};
   end

   assign soft_in = neg_chain[CORDIC_STEPS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= v_chain[CORDIC_STEPS];
      end
      x_ff    <= x_chain[CORDIC_STEPS];
      soft_ff <= soft_in;
      hard_ff <= hard_chain[CORDIC_STEPS];
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_soft  = soft_ff;
   assign out_hard  = hard_ff;

endmodule

// ----- hdl/scd_mix.sv -----
// Crossfades soft/hard, then distorted/clean, applies the volume and saturates.
// Six register stages, a product stage before each rounding add. Depends on scd_pkg.
module scd_mix #(
   parameter int SW = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [SW-1:0] in_x,
   input  logic signed [SW:0]   in_soft,
   input  logic signed [SW:0]   in_hard,
   input  scd_pkg::mix_type     hard_mix,
   input  scd_pkg::mix_type     wet_mix,
   input  scd_pkg::vol_type     output_gain,
   output logic                 out_valid,
   output logic signed [SW-1:0] out_sample,
   output logic                 out_saturated
);
   import scd_pkg::*;

   localparam int FB = SW - 1;
   localparam int HW = SW + 1;
   localparam int PW = HW + MIX_WIDTH + 1;
   localparam int SUMW = PW + 1;
   localparam int QW = HW + VOL_WIDTH + 1;
   localparam int YSW = QW + 1;
   localparam int YW = SW + 3;
   localparam logic signed [SUMW-1:0] HALF_MIX = SUMW'(1) << (MIX_FRAC - 1);
   localparam logic signed [YSW-1:0]  HALF_VOL = YSW'(1) << (MIX_FRAC - 1);
   localparam logic signed [YW-1:0]   Y_HI = (YW'(1) << FB) - YW'(1);
   localparam logic signed [YW-1:0]   Y_LO = -(YW'(1) << FB);

   mix_type h, hc, w, wc;

   // Soft/hard crossfade.
   logic signed [PW-1:0]   p1_soft_in, p1_hard_in;
   logic                   p1_valid_ff;
   logic signed [PW-1:0]   p1_soft_ff, p1_hard_ff;
   logic signed [SW-1:0]   p1_x_ff;
   logic signed [SUMW-1:0] s1_sum;
   logic                   s1_valid_ff;
   logic signed [HW-1:0]   s1_dist_ff;
   logic signed [SW-1:0]   s1_x_ff;

   // Wet/clean crossfade.
   logic signed [PW-1:0]   p2_clean_in, p2_wet_in;
   logic                   p2_valid_ff;
   logic signed [PW-1:0]   p2_clean_ff, p2_wet_ff;
   logic signed [SUMW-1:0] s2_sum;
   logic                   s2_valid_ff;
   logic signed [HW-1:0]   s2_mix_ff;

   // Volume and saturation.
   logic signed [QW-1:0]   p3_prod_in;
   logic                   p3_valid_ff;
   logic signed [QW-1:0]   p3_prod_ff;
   logic signed [YSW-1:0]  y_sum;
   logic signed [YW-1:0]   y;
   logic signed [SW-1:0]   sample_in;
   logic                   sat_in;
   logic                   o_valid_ff;
   logic signed [SW-1:0]   o_sample_ff;
   logic                   o_sat_ff;

   always_comb begin
      h  = (hard_mix > MIX_UNITY) ? MIX_UNITY : hard_mix;
      w  = (wet_mix > MIX_UNITY) ? MIX_UNITY : wet_mix;
      hc = MIX_UNITY - h;
      wc = MIX_UNITY - w;
   end

   assign p1_soft_in = in_soft * $signed({1'b0, hc});
   assign p1_hard_in = in_hard * $signed({1'b0, h});

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= in_valid;
      end
      p1_soft_ff <= p1_soft_in;
      p1_hard_ff <= p1_hard_in;
      p1_x_ff    <= in_x;
   end

   assign s1_sum = SUMW'(p1_soft_ff) + SUMW'(p1_hard_ff) + HALF_MIX;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= p1_valid_ff;
      end
      s1_dist_ff <= s1_sum[MIX_FRAC +: HW];
      s1_x_ff    <= p1_x_ff;
   end

   assign p2_clean_in = s1_x_ff * $signed({1'b0, wc});
   assign p2_wet_in   = s1_dist_ff * $signed({1'b0, w});

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= s1_valid_ff;
      end
      p2_clean_ff <= p2_clean_in;
      p2_wet_ff   <= p2_wet_in;
   end

   assign s2_sum = SUMW'(p2_clean_ff) + SUMW'(p2_wet_ff) + HALF_MIX;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= p2_valid_ff;
      end
      s2_mix_ff <= s2_sum[MIX_FRAC +: HW];
   end

   assign p3_prod_in = s2_mix_ff * $signed({1'b0, output_gain});

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= s2_valid_ff;
      end
      p3_prod_ff <= p3_prod_in;
   end

   always_comb begin
      y_sum = YSW'(p3_prod_ff) + HALF_VOL;
      y     = y_sum[MIX_FRAC +: YW];
      if (y > Y_HI) begin
         sample_in = Y_HI[SW-1:0];
         sat_in    = 1'b1;
      end else if (y < Y_LO) begin
         sample_in = Y_LO[SW-1:0];
         sat_in    = 1'b1;
      end else begin
         sample_in = y[SW-1:0];
         sat_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         o_sat_ff   <= 1'b0;
      end else begin
         o_valid_ff <= p3_valid_ff;
         o_sat_ff   <= p3_valid_ff & sat_in;
      end
      o_sample_ff <= sample_in;
   end

   assign out_valid     = o_valid_ff;
   assign out_sample    = o_sample_ff;
   assign out_saturated = o_sat_ff;

endmodule

// ----- tb/scd_tb_pkg.sv -----
// Scoreboard for the soft/hard clip distortion testbench: a bit-exact predictor
// of one sample and a queue of the outputs still awaited from the block.
// Depends on scd_pkg for register types, register indexes and the CORDIC angle table.
package scd_tb_pkg;

   import scd_pkg::*;

   localparam int SAMPLE_W     = 24;
   localparam int FRAC         = SAMPLE_W - 1;
   localparam int REPORT_LIMIT = 25;

   typedef logic signed [SAMPLE_W-1:0] audio_sample_type;

   typedef struct packed {
      audio_sample_type out_sample;
      logic             saturated;
   } clip_result_type;

   class distortion_scoreboard;
      drive_type       drive_gain  = DRIVE_GAIN_RESET;
      mix_type         hard_mix    = HARD_MIX_RESET;
      mix_type         wet_mix     = WET_MIX_RESET;
      vol_type         output_gain = OUTPUT_GAIN_RESET;
      clip_result_type awaited_outputs [$];
      int              mismatch_count  = 0;
      int              checked_count   = 0;
      int              saturated_count = 0;

      // Bits above each register's width are dropped, as the block does.
      function void set_register(csr_index_type idx, csr_data_type value);
         case (idx)
            REG_DRIVE_GAIN:  drive_gain  = value[DRIVE_WIDTH-1:0];
            REG_HARD_MIX:    hard_mix    = value[MIX_WIDTH-1:0];
            REG_WET_MIX:     wet_mix     = value[MIX_WIDTH-1:0];
            REG_OUTPUT_GAIN: output_gain = value[VOL_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function longint round_q16(longint v);
         return (v + (longint'(1) << (MIX_FRAC - 1))) >>> MIX_FRAC;
      endfunction

      function clip_result_type predict_clip(audio_sample_type sample);
         longint          x, d, cx, cy, z, sx, sy;
         longint          soft_val, hard, h, w, dist_val, mix, y, full_d;
         int              i;
         clip_result_type r;
         x      = longint'(sample);
         d      = x * longint'(drive_gain);
         full_d = longint'(1) << (FRAC + GAIN_FRAC);
         // Vectoring CORDIC on (1.0, |d|); z collects the angle in units of pi/2.
         cx = full_d;
         cy = (d < 0) ? -d : d;
         z  = 0;
         for (i = 0; i < CORDIC_STEPS; i++) begin
            sx = cy >>> i;
            sy = cx >>> i;
            if (cy >= 0) begin
               cx = cx + sx;
               cy = cy - sy;
               z  = z + longint'(CORDIC_ANGLE[i]);
            end else begin
               cx = cx - sx;
               cy = cy + sy;
               z  = z - longint'(CORDIC_ANGLE[i]);
            end
         end
         if (z < 0) z = 0;
         if (z > (longint'(1) << ANGLE_FRAC)) z = longint'(1) << ANGLE_FRAC;
         soft_val = (z + (longint'(1) << (ANGLE_FRAC - FRAC - 1))) >>> (ANGLE_FRAC - FRAC);
         if (d < 0) soft_val = -soft_val;

         if (d >= full_d) hard = longint'(1) << FRAC;
         else if (d <= -full_d) hard = -(longint'(1) << FRAC);
         else hard = d >>> GAIN_FRAC;

         h        = (hard_mix > MIX_UNITY) ? longint'(MIX_UNITY) : longint'(hard_mix);
         w        = (wet_mix > MIX_UNITY) ? longint'(MIX_UNITY) : longint'(wet_mix);
         dist_val = round_q16(soft_val * (longint'(MIX_UNITY) - h) + hard * h);
         mix      = round_q16(x * (longint'(MIX_UNITY) - w) + dist_val * w);
         y        = round_q16(mix * longint'(output_gain));

         r.saturated = 1'b0;
         if (y > (longint'(1) << FRAC) - 1) begin
            y = (longint'(1) << FRAC) - 1;
            r.saturated = 1'b1;
         end else if (y < -(longint'(1) << FRAC)) begin
            y = -(longint'(1) << FRAC);
            r.saturated = 1'b1;
         end
         r.out_sample = y[SAMPLE_W-1:0];
         return r;
      endfunction

      task report_mismatch(string what);
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) $display("MISMATCH: %s", what);
      endtask

      function void note_sample(audio_sample_type sample);
         awaited_outputs.push_back(predict_clip(sample));
      endfunction

      task check_output(audio_sample_type out_sample, logic saturated);
         clip_result_type want;
         if (awaited_outputs.size() == 0) begin
            report_mismatch($sformatf("output %0d arrived with no transaction waiting",
                                      out_sample));
            return;
         end
         want = awaited_outputs.pop_front();
         checked_count++;
         if (want.saturated) saturated_count++;
         if (out_sample !== want.out_sample)
            report_mismatch($sformatf("transaction %0d: out_sample %0d, expected %0d",
                                      checked_count, out_sample, want.out_sample));
         if (saturated !== want.saturated)
            report_mismatch($sformatf("transaction %0d: saturated %b, expected %b",
                                      checked_count, saturated, want.saturated));
      endtask

      function int pending();
         return awaited_outputs.size();
      endfunction

      task close_out();
         if (awaited_outputs.size() != 0)
            report_mismatch($sformatf("%0d expected outputs never arrived",
                                      awaited_outputs.size()));
      endtask
   endclass

endpackage

// ----- tb/testbench.sv -----
// Top-level testbench for soft_hard_clip_distortion_top: drives samples and register
// writes, watches the result strobe and checks every output against the scoreboard.
// Depends on scd_pkg and scd_tb_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import scd_pkg::*;
   import scd_tb_pkg::*;

   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 50;

   logic             clock         = 1'b0;
   logic             reset         = 1'b1;
   logic             start         = 1'b0;
   logic             busy;
   audio_sample_type req_in_sample = '0;
   logic             rsp_valid;
   audio_sample_type rsp_out_sample;
   logic             rsp_saturated;
   logic             csr_write     = 1'b0;
   csr_index_type    csr_index     = REG_DRIVE_GAIN;
   csr_data_type     csr_wdata     = '0;

   drive_type            drive_now      = DRIVE_GAIN_RESET;
   int                   settings_count = 0;
   distortion_scoreboard board          = new;

   soft_hard_clip_distortion_top #(.SAMPLE_WIDTH(SAMPLE_W)) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_in_sample  (req_in_sample),
      .rsp_valid      (rsp_valid),
      .rsp_out_sample (rsp_out_sample),
      .rsp_saturated  (rsp_saturated),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   // Both channels are sampled with the values they held just before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_sample(req_in_sample);
         if (rsp_valid) board.check_output(rsp_out_sample, rsp_saturated);
      end
   end

   task automatic write_register(input csr_index_type idx, input csr_data_type value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.set_register(idx, value);
   endtask

   task automatic apply_settings(input csr_data_type drive, input csr_data_type hard,
                                 input csr_data_type wet, input csr_data_type volume);
      write_register(REG_DRIVE_GAIN, drive);
      write_register(REG_HARD_MIX, hard);
      write_register(REG_WET_MIX, wet);
      write_register(REG_OUTPUT_GAIN, volume);
      csr_write <= 1'b0;
      drive_now = drive[DRIVE_WIDTH-1:0];
      settings_count++;
   endtask

   // The first edge lets the monitor record a transaction accepted at this step.
   task automatic wait_for_drain();
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic send_sample(input audio_sample_type sample, input int idle_pct);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start         <= 1'b1;
      req_in_sample <= sample;
      do @(posedge clock); while (busy);
   endtask

   function automatic audio_sample_type random_sample();
      longint v;
      int     k;
      case ($urandom_range(4))
         0: begin
            k = $urandom_range(FRAC - 1);
            v = longint'($urandom_range(0, 1 << k));
            if ($urandom_range(1)) v = -v;
         end
         1: begin
            case ($urandom_range(3))
               0:       v = (longint'(1) << FRAC) - 1;
               1:       v = -(longint'(1) << FRAC);
               2:       v = 1;
               default: v = -1;
            endcase
         end
         2: begin
            // Around the input level at which the driven signal reaches full scale.
            v = (drive_now == 0) ? 0 :
                (longint'(1) << (FRAC + GAIN_FRAC)) / longint'(drive_now);
            v = v + longint'($urandom_range(0, 8)) - 4;
            if ($urandom_range(1)) v = -v;
         end
         default: v = longint'(audio_sample_type'($urandom()));
      endcase
      if (v > (longint'(1) << FRAC) - 1) v = (longint'(1) << FRAC) - 1;
      if (v < -(longint'(1) << FRAC)) v = -(longint'(1) << FRAC);
      return v[SAMPLE_W-1:0];
   endfunction

   initial begin
      audio_sample_type directed [13] = '{
         0, 1, -1, 8388607, -8388608, 4194304, -4194304,
         8191, -8192, 1048576, -3000000, 5592405, -5592406
      };
      int idle_pct;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_sample(directed[i], 0);
      start <= 1'b0;
      wait_for_drain();
      // Near-maximum drive, both mixes above unity and the volume beyond 2.0.
      apply_settings(128000, 131071, 131071, 262143);
      for (int i = 0; i < 11; i++) send_sample(directed[i], 0);
      start <= 1'b0;
      wait_for_drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       apply_settings(256, 0, 65536, 65536);
            1:       apply_settings(0, 18'h30000, 0, 0);
            2:       apply_settings(1, 65536, 98304, 131072);
            3:       apply_settings(131071, 32768, 65536, 1);
            default: apply_settings(
                        csr_data_type'(($urandom_range(3) == 0) ? $urandom_range(0, 131071)
                                                                : $urandom_range(128, 4096)),
                        csr_data_type'($urandom_range(0, 70000)),
                        csr_data_type'($urandom_range(0, 70000)),
                        csr_data_type'($urandom_range(0, 262143)));
         endcase
         idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 84 : 21;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Hold the sender off in mid-phase until the pipeline is empty.
            if (n == PHASE_ITEMS / 2 && p % 2 == 1) begin
               start <= 1'b0;
               wait_for_drain();
            end
            send_sample(random_sample(), idle_pct);
         end
         start <= 1'b0;
         wait_for_drain();
      end

      repeat (LATENCY + 8) @(posedge clock);
      board.close_out();
      $display("Ran %0d register settings plus the reset values; %0d transactions checked,",
               settings_count, board.checked_count);
      $display("%0d of them saturated.", board.saturated_count);
      if (board.mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d outputs still awaited.", board.pending());
      $display("status: fail");
      $finish;
   end

endmodule
